[hdl/frkvc_pkg.sv]
// ----------------------------------------------------------------------------
// frkvc_pkg
// Shared types and constants for the fifo-replacement key/value cache.
// ----------------------------------------------------------------------------
package frkvc_pkg;

  // port field widths
  localparam int MODE_W  = 2;
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int COUNT_W = 6;
  localparam int LIMIT_W = 6;

  // default sizing
  localparam int MAX_ENTRIES_DEF = 32;
  localparam int KEY_BITS_DEF    = 64;
  localparam int VALUE_BITS_DEF  = 64;

  // limit register value after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd20;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp_en;     // capture key compare into match flag
    logic in_range;   // cell holds a valid entry
    logic load_new;   // load the incoming key/value
    logic take_next;  // take key/value/match from the younger neighbor
  } cell_ctl_t;

endpackage

[hdl/frkvc_if.sv]
// ----------------------------------------------------------------------------
// frkvc channel interfaces
// Valid/ready channels for requests, results and the limit register write.
// ----------------------------------------------------------------------------
interface frkvc_in_if;
  logic                             valid;
  logic                             ready;
  logic [frkvc_pkg::MODE_W-1:0]     mode;
  logic [frkvc_pkg::KEY_W-1:0]      lookup_key;
  logic [frkvc_pkg::VAL_W-1:0]      entry_value;

  modport source (output valid, mode, lookup_key, entry_value, input ready);
  modport sink   (input valid, mode, lookup_key, entry_value, output ready);
endinterface

interface frkvc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [frkvc_pkg::VAL_W-1:0]      found_value;
  logic [frkvc_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, hit, found_value, entry_count, input ready);
  modport sink   (input valid, hit, found_value, entry_count, output ready);
endinterface

interface frkvc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [frkvc_pkg::LIMIT_W-1:0]    entry_limit;

  modport source (output valid, entry_limit, input ready);
  modport sink   (input valid, entry_limit, output ready);
endinterface

[hdl/frkvc_cell.sv]
// ----------------------------------------------------------------------------
// frkvc_cell
// One storage slot: key, value and match flag, with a key comparator and a
// shift path from the younger neighbor.
// ----------------------------------------------------------------------------
module frkvc_cell #(
  parameter int KEY_BITS   = frkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = frkvc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  frkvc_pkg::cell_ctl_t  ctl,
  input  logic [KEY_BITS-1:0]   key_in,
  input  logic [VALUE_BITS-1:0] val_in,
  input  logic [KEY_BITS-1:0]   nb_key,
  input  logic [VALUE_BITS-1:0] nb_val,
  input  logic                  nb_match,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] val_o,
  output logic                  match_o
);

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  match_r;

  // slot contents
  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      key_r <= key_in;
      val_r <= val_in;
    end else if (ctl.take_next) begin
      key_r <= nb_key;
      val_r <= nb_val;
    end
  end

  // match flag, shifts along with the entry
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      match_r <= ctl.in_range && (key_r == key_in);
    end else if (ctl.take_next) begin
      match_r <= nb_match;
    end
  end

  assign key_o   = key_r;
  assign val_o   = val_r;
  assign match_o = match_r;

endmodule

[hdl/fifo_replacement_key_value_cache.sv]
// ----------------------------------------------------------------------------
// fifo_replacement_key_value_cache
// Fully associative key/value store in insertion order, built as a row of
// slots that shift toward the oldest end on eviction and removal.
// ----------------------------------------------------------------------------
// lookup, add and clear: accepted in IDLE, keys compared in CMP, result registered out of EXEC
// remove stays in EXEC, shifting out the oldest matching entry each time until no match is left
// one item in flight; the next is accepted the cycle after the result is registered
// EXEC holds while the previous result still waits on the result channel
// reset: entry count 0, limit 20; slot contents stay undefined and are never read
// ----------------------------------------------------------------------------
module fifo_replacement_key_value_cache #(
  parameter int MAX_ENTRIES = frkvc_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = frkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = frkvc_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  frkvc_in_if.sink    in_chan,
  frkvc_out_if.source out_chan,
  frkvc_cfg_if.sink   cfg_chan
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int LW    = (CNT_W > frkvc_pkg::LIMIT_W) ? CNT_W : frkvc_pkg::LIMIT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0]                       state_r, state_nxt;
  logic [frkvc_pkg::MODE_W-1:0]     mode_r;
  logic [KEY_BITS-1:0]              key_r;
  logic [VALUE_BITS-1:0]            val_r;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [frkvc_pkg::LIMIT_W-1:0]    limit_r;

  logic                             out_valid_r, out_valid_nxt;
  logic                             out_hit_r;
  logic [VALUE_BITS-1:0]            out_value_r;
  logic [CNT_W-1:0]                 out_count_r;

  logic [KEY_BITS-1:0]              key_a    [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]            val_a    [MAX_ENTRIES];
  logic [KEY_BITS-1:0]              nb_key_a [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]            nb_val_a [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]           match_v, nb_match_v;
  frkvc_pkg::cell_ctl_t             ctl_a    [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0]           first_oh, tail_mask;
  logic                             any_match;
  logic [VALUE_BITS-1:0]            found_val;
  logic [LW-1:0]                    lim_w, eff_lim;
  logic                             full;
  logic [CNT_W-1:0]                 last_idx;
  logic                             out_free, finish;
  logic                             in_fire, cfg_fire;

  // handshakes
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = (state_r == ST_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_fire       = cfg_chan.valid && cfg_chan.ready;
  assign out_free       = !out_valid_r || out_chan.ready;

  // effective limit clamped to 1..MAX_ENTRIES
  always_comb begin
    lim_w = LW'(limit_r);
    if (lim_w == '0) begin
      eff_lim = LW'(1);
    end else if (lim_w > LW'(MAX_ENTRIES)) begin
      eff_lim = LW'(MAX_ENTRIES);
    end else begin
      eff_lim = lim_w;
    end
  end
  assign full     = (LW'(count_r) >= eff_lim);
  assign last_idx = count_r - CNT_W'(1);

  // oldest match and everything from it toward the young end
  assign first_oh  = match_v & (~match_v + MAX_ENTRIES'(1));
  assign tail_mask = ~(first_oh - MAX_ENTRIES'(1));
  assign any_match = |match_v;

  // value of the oldest matching slot
  always_comb begin
    found_val = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      found_val = found_val | ({VALUE_BITS{first_oh[i]}} & val_a[i]);
    end
  end

  // per-slot controls
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ctl_a[i].cmp_en    = (state_r == ST_CMP);
      ctl_a[i].in_range  = (CNT_W'(i) < count_r);
      ctl_a[i].load_new  = 1'b0;
      ctl_a[i].take_next = 1'b0;
      if (state_r == ST_EXEC) begin
        if (mode_r == frkvc_pkg::MODE_ADD && out_free) begin
          if (full) begin
            ctl_a[i].take_next = (CNT_W'(i) < last_idx);
            ctl_a[i].load_new  = (CNT_W'(i) == last_idx);
          end else begin
            ctl_a[i].load_new  = (CNT_W'(i) == count_r);
          end
        end else if (mode_r == frkvc_pkg::MODE_REMOVE && any_match) begin
          ctl_a[i].take_next = tail_mask[i];
        end
      end
    end
  end

  // row of slots, each fed by its younger neighbor
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == MAX_ENTRIES - 1) begin : g_end
      assign nb_key_a[g]   = '0;
      assign nb_val_a[g]   = '0;
      assign nb_match_v[g] = 1'b0;
    end else begin : g_mid
      assign nb_key_a[g]   = key_a[g+1];
      assign nb_val_a[g]   = val_a[g+1];
      assign nb_match_v[g] = match_v[g+1];
    end

    frkvc_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl_a[g]),
      .key_in   (key_r),
      .val_in   (val_r),
      .nb_key   (nb_key_a[g]),
      .nb_val   (nb_val_a[g]),
      .nb_match (nb_match_v[g]),
      .key_o    (key_a[g]),
      .val_o    (val_a[g]),
      .match_o  (match_v[g])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    finish    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_fire) begin
          count_nxt = '0;
        end
        if (in_fire) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (mode_r)
          frkvc_pkg::MODE_LOOKUP: begin
            finish = out_free;
          end
          frkvc_pkg::MODE_ADD: begin
            finish = out_free;
            if (out_free && !full) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
          frkvc_pkg::MODE_REMOVE: begin
            if (any_match) begin
              count_nxt = last_idx;
            end else begin
              finish = out_free;
            end
          end
          frkvc_pkg::MODE_CLEAR: begin
            finish = out_free;
            if (out_free) begin
              count_nxt = '0;
            end
          end
          default: begin
            finish = out_free;
          end
        endcase
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      limit_r     <= frkvc_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        limit_r <= cfg_chan.entry_limit;
      end
    end
  end

  // request beat capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_chan.mode;
      key_r  <= in_chan.lookup_key[KEY_BITS-1:0];
      val_r  <= in_chan.entry_value[VALUE_BITS-1:0];
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_hit_r   <= (mode_r == frkvc_pkg::MODE_LOOKUP) && any_match;
      out_value_r <= (mode_r == frkvc_pkg::MODE_LOOKUP) ? found_val : '0;
      out_count_r <= count_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.hit         = out_hit_r;
  assign out_chan.found_value = frkvc_pkg::VAL_W'(out_value_r);
  assign out_chan.entry_count = frkvc_pkg::COUNT_W'(out_count_r);

  // count stays within the applied limit
  a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(count_r) <= eff_lim)
    else $error("entry count above limit");

  // each remove shift drops exactly one entry
  a_remove_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && mode_r == frkvc_pkg::MODE_REMOVE && any_match)
      |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("remove step count mismatch");

  // oldest-match select is one-hot or empty while executing
  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $onehot0(first_oh))
    else $error("oldest-match select not one-hot");

  // a result only appears out of the execute step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EXEC))
    else $error("result without execute step");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives lookup, add, remove and clear requests into the key/value cache and
// mirrors the store as an ordered queue of entries. Each result beat is
// compared with the mirror's prediction. Runs several limit settings with
// different amounts of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT  = 5000;  // cycles with no beat on any channel
  localparam int DRAIN_CYCLES = 40;    // covers the longest remove, which shifts out every stored entry
  localparam int CFG_SETTLE   = 2;

  typedef struct packed {
    logic                          hit;
    logic [frkvc_pkg::VAL_W-1:0]   found_value;
    logic [frkvc_pkg::COUNT_W-1:0] entry_count;
  } cache_result_t;

  // ordered copy of the store plus the results it predicts
  class cache_mirror;
    logic [frkvc_pkg::KEY_W-1:0]   keys[$];
    logic [frkvc_pkg::VAL_W-1:0]   vals[$];
    logic [frkvc_pkg::LIMIT_W-1:0] limit_reg = frkvc_pkg::LIMIT_RESET;
    cache_result_t                 pending_results[$];
    int                            errors = 0;

    // writing the limit also empties the store
    function void set_limit(logic [frkvc_pkg::LIMIT_W-1:0] lim);
      limit_reg = lim;
      keys.delete();
      vals.delete();
    endfunction

    // zero acts as one, anything above capacity as capacity
    function int applied_limit();
      if (limit_reg == '0) return 1;
      if (limit_reg > frkvc_pkg::MAX_ENTRIES_DEF) return frkvc_pkg::MAX_ENTRIES_DEF;
      return int'(limit_reg);
    endfunction

    function void note_request(logic [frkvc_pkg::MODE_W-1:0] mode,
                               logic [frkvc_pkg::KEY_W-1:0] key,
                               logic [frkvc_pkg::VAL_W-1:0] value);
      cache_result_t               res;
      logic [frkvc_pkg::KEY_W-1:0] kept_keys[$];
      logic [frkvc_pkg::VAL_W-1:0] kept_vals[$];
      res = '0;
      case (mode)
        frkvc_pkg::MODE_LOOKUP: begin
          // oldest matching entry wins
          foreach (keys[i]) begin
            if (!res.hit && keys[i] == key) begin
              res.hit = 1'b1;
              res.found_value = vals[i];
            end
          end
        end
        frkvc_pkg::MODE_ADD: begin
          // full: drop the oldest, new entry goes last
          if (keys.size() >= applied_limit()) begin
            void'(keys.pop_front());
            void'(vals.pop_front());
            keys = {keys, key};
            vals = {vals, value};
          end else if (keys.size() < frkvc_pkg::MAX_ENTRIES_DEF) begin
            keys = {keys, key};
            vals = {vals, value};
          end
        end
        frkvc_pkg::MODE_REMOVE: begin
          // drop every copy, keep the rest in order
          foreach (keys[i]) begin
            if (keys[i] != key) begin
              kept_keys = {kept_keys, keys[i]};
              kept_vals = {kept_vals, vals[i]};
            end
          end
          keys = kept_keys;
          vals = kept_vals;
        end
        frkvc_pkg::MODE_CLEAR: begin
          keys.delete();
          vals.delete();
        end
      endcase
      res.entry_count = frkvc_pkg::COUNT_W'(keys.size());
      pending_results = {pending_results, res};
    endfunction

    function void check_result(logic hit, logic [frkvc_pkg::VAL_W-1:0] found_value,
                               logic [frkvc_pkg::COUNT_W-1:0] entry_count);
      cache_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: hit=%0b value=%h count=%0d",
                 $time, hit, found_value, entry_count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit, hit);
        errors++;
      end
      if (found_value !== want.found_value) begin
        $display("%0t: found_value mismatch: expected %h, actual %h",
                 $time, want.found_value, found_value);
        errors++;
      end
      if (entry_count !== want.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                 $time, want.entry_count, entry_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  logic [frkvc_pkg::KEY_W-1:0] key_pool[$];
  cache_mirror mirror = new;

  frkvc_in_if  in_chan();
  frkvc_out_if out_chan();
  frkvc_cfg_if cfg_chan();

  fifo_replacement_key_value_cache DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result back-pressure
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (out_chan.valid && out_chan.ready)
      mirror.check_result(out_chan.hit, out_chan.found_value, out_chan.entry_count);
  end

  // watchdog on cycles with no beat anywhere
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // one request beat, then a random sender gap with probability idle_pct
  task automatic send_request(logic [frkvc_pkg::MODE_W-1:0] mode,
                              logic [frkvc_pkg::KEY_W-1:0] key,
                              logic [frkvc_pkg::VAL_W-1:0] value);
    in_chan.valid       <= 1'b1;
    in_chan.mode        <= mode;
    in_chan.lookup_key  <= key;
    in_chan.entry_value <= value;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    mirror.note_request(mode, key, value);
    if ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  // limit write once the cache has gone quiet
  task automatic write_limit(logic [frkvc_pkg::LIMIT_W-1:0] lim);
    in_chan.valid <= 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_chan.valid       <= 1'b1;
    cfg_chan.entry_limit <= lim;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    mirror.set_limit(lim);
    cfg_chan.valid <= 1'b0;
  endtask

  // random traffic drawn mostly from a small key pool so lookups hit
  task automatic run_phase(int n_items, int pool_size);
    logic [frkvc_pkg::MODE_W-1:0] mode;
    logic [frkvc_pkg::KEY_W-1:0]  key;
    int                           pick;
    key_pool.delete();
    repeat (pool_size) begin
      key = {$urandom, $urandom};
      key_pool = {key_pool, key};
    end
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 40)      mode = frkvc_pkg::MODE_LOOKUP;
      else if (pick < 88) mode = frkvc_pkg::MODE_ADD;
      else if (pick < 99) mode = frkvc_pkg::MODE_REMOVE;
      else                mode = frkvc_pkg::MODE_CLEAR;
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(pool_size - 1)];
      else                         key = {$urandom, $urandom};
      send_request(mode, key, {$urandom, $urandom});
    end
  endtask

  initial begin
    logic [frkvc_pkg::KEY_W-1:0]   all_ones;
    logic [frkvc_pkg::LIMIT_W-1:0] lim;
    int phase_limit[6];
    int phase_idle[6];
    int phase_stall[6];
    int phase_pool[6];

    phase_limit = '{1, 0, 63, 32, 2, 20};
    phase_idle  = '{0, 81, 0, 33, 0, 33};
    phase_stall = '{0, 0, 81, 33, 0, 33};
    phase_pool  = '{3, 4, 40, 16, 6, 10};

    all_ones = '1;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.mode         <= frkvc_pkg::MODE_LOOKUP;
    in_chan.lookup_key   <= '0;
    in_chan.entry_value  <= '0;
    cfg_chan.valid       <= 1'b0;
    cfg_chan.entry_limit <= frkvc_pkg::LIMIT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, extreme keys and values, duplicates, all ops
    send_request(frkvc_pkg::MODE_LOOKUP, '0, all_ones);
    send_request(frkvc_pkg::MODE_ADD, '0, all_ones);
    send_request(frkvc_pkg::MODE_ADD, all_ones, '0);
    send_request(frkvc_pkg::MODE_ADD, '0, 64'h5a5a_a5a5_0f0f_f0f0);
    send_request(frkvc_pkg::MODE_LOOKUP, '0, '0);
    send_request(frkvc_pkg::MODE_LOOKUP, all_ones, all_ones);
    send_request(frkvc_pkg::MODE_LOOKUP, 64'h1234, '0);
    send_request(frkvc_pkg::MODE_REMOVE, '0, all_ones);
    send_request(frkvc_pkg::MODE_LOOKUP, '0, '0);
    send_request(frkvc_pkg::MODE_REMOVE, 64'h1234, '0);
    send_request(frkvc_pkg::MODE_LOOKUP, all_ones, '0);
    send_request(frkvc_pkg::MODE_CLEAR, all_ones, all_ones);
    send_request(frkvc_pkg::MODE_REMOVE, all_ones, '0);
    send_request(frkvc_pkg::MODE_LOOKUP, all_ones, '0);
    send_request(frkvc_pkg::MODE_ADD, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
    send_request(frkvc_pkg::MODE_ADD, 64'h7fff_ffff_ffff_fffe, 64'h7fff_ffff_ffff_fffe);
    send_request(frkvc_pkg::MODE_LOOKUP, 64'h7fff_ffff_ffff_fffe, '0);
    send_request(frkvc_pkg::MODE_CLEAR, '0, '0);

    // random phases across limit settings and idling mixes
    for (int p = 0; p < 6; p++) begin
      lim = (p == 5) ? frkvc_pkg::LIMIT_W'($urandom_range(3, 31))
                     : frkvc_pkg::LIMIT_W'(phase_limit[p]);
      write_limit(lim);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      run_phase(190, phase_pool[p]);
    end

    // drain and settle
    in_chan.valid <= 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[fifo_replacement_key_value_cache.f]
hdl/frkvc_pkg.sv
hdl/frkvc_if.sv
hdl/frkvc_cell.sv
hdl/fifo_replacement_key_value_cache.sv
tb/tb.sv
